/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers. They compile to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checks that an expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
// Checks that a condition implies a consequence in the same cycle.
`define ASSERT_IMPLIES(lbl, clk, rst_n, cond, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ASSERT_IMPLIES(lbl, clk, rst_n, cond, cons)
`endif
`endif

/* rtl/kfh_pkg.sv */
// ----------------------------------------------------------------------------
// kfh_pkg
// Shared constants and the cell operation codes of the fraction selector.
// ----------------------------------------------------------------------------
`default_nettype none
package kfh_pkg;
    localparam int MAX_LEN_DEF    = 2048;
    localparam int VALUE_BITS_DEF = 15;
    localparam int RANK_W         = 22;

    // Operation broadcast to every cell of the sorted chain.
    typedef enum logic [2:0] {
        OP_HOLD,
        OP_CLEAR,
        OP_INSERT,
        OP_POP,
        OP_REPL
    } t_op;
endpackage
`default_nettype wire

/* rtl/kth_smallest_fraction_heap.sv */
// ----------------------------------------------------------------------------
// kth_smallest_fraction_heap
// Selects the k-th smallest fraction A[i]/A[j], i < j, of a loaded list.
// ----------------------------------------------------------------------------
// List elements arrive one per cycle on the slave stream; the transfer with
// tlast closes the list and carries the one-based rank k. Elements past
// MAX_LEN are dropped. A bad request (fewer than two elements, k of zero, or
// k above n(n-1)/2) yields one result transfer at once with the error flag
// set and zero data. Otherwise the block orders all candidate fractions in a
// chain of MAX_LEN-1 cells kept sorted, smallest in the head cell: seeding
// takes 2n - 1 cycles (two to fetch the last element and the first
// numerator, one chain insert per entry, and one element store read before
// every entry after the first), then each of the k-1 removals takes one
// cycle when the popped row is used up and two cycles when its next fraction
// must be read from the element store and inserted, and one more cycle
// loads the answer. The result leaves through an output register.
// The input stream is not ready while a selection runs; fraction ties sort
// the larger numerator index first, compared exactly by cross products.
`default_nettype none
`include "assert_macros.svh"
module kth_smallest_fraction_heap
    import kfh_pkg::*;
#(
    parameter int MAX_LEN    = MAX_LEN_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    localparam int IN_W      = ((VALUE_BITS + RANK_W + 7) / 8) * 8,
    localparam int OUT_W     = ((2 * VALUE_BITS + 7) / 8) * 8
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // Fields from bit 0: value, rank, zero fill.
    input  wire logic [IN_W-1:0] i_s_axis_tdata,
    input  wire logic            i_s_axis_tlast,
    output logic                 o_m_axis_tvalid,
    input  wire logic            i_m_axis_tready,
    // Fields from bit 0: numerator, denominator, zero fill.
    output logic [OUT_W-1:0]     o_m_axis_tdata,
    // Fields from bit 0: error.
    output logic                 o_m_axis_tuser
);
    localparam int VB    = VALUE_BITS;
    localparam int IDX_W = $clog2(MAX_LEN);
    localparam int CNT_W = $clog2(MAX_LEN + 1);
    localparam int NCELL = MAX_LEN - 1;
    localparam int ENT_W = 1 + 2 * IDX_W + 2 * VB;
    localparam int TW    = 2 * CNT_W + RANK_W + 1;

    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] i;
        logic [IDX_W-1:0] j;
        logic [VB-1:0]    vi;
        logic [VB-1:0]    vj;
    } t_ent;

    typedef enum logic [2:0] {
        S_LOAD,
        S_QRD,
        S_QCAP,
        S_SRD,
        S_SINS,
        S_PSEL,
        S_PREP
    } t_state;

    t_state           r_state;
    logic [CNT_W-1:0] r_cnt;
    logic [IDX_W-1:0] r_nm1;
    logic [IDX_W-1:0] r_i;
    logic [VB-1:0]    r_vq;
    logic [RANK_W-1:0] r_pops;
    logic             r_out_valid;
    logic [VB-1:0]    r_num;
    logic [VB-1:0]    r_den;
    logic             r_err;

    // Element store.
    logic [VB-1:0]    r_mem [MAX_LEN];
    logic [VB-1:0]    r_rd;
    logic [IDX_W-1:0] w_rd_addr;

    // Chain wiring: index NCELL is an empty slot past the tail.
    logic [ENT_W-1:0] w_ent [NCELL+1];
    logic             w_b   [NCELL+1];
    logic [NCELL-1:0] w_valid;
    t_op              w_op;
    t_ent             w_x;
    t_ent             w_top;

    logic [VB-1:0]     w_value;
    logic [RANK_W-1:0] w_rank;
    logic              w_in_acc;
    logic              w_full;
    logic [CNT_W-1:0]  w_n;
    logic [2*CNT_W-1:0] w_pairs2;
    logic              w_bad;
    logic              w_advance;
    logic              w_out_free;
    logic              w_out_load;

    assign w_value    = i_s_axis_tdata[VB-1:0];
    assign w_rank     = i_s_axis_tdata[VB+RANK_W-1:VB];
    assign w_out_free = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = (r_state == S_LOAD) && w_out_free;
    assign w_in_acc   = i_s_axis_tvalid && o_s_axis_tready;

    // Request check: 2k must not exceed n(n-1).
    assign w_full   = (r_cnt == CNT_W'(MAX_LEN));
    assign w_n      = w_full ? r_cnt : r_cnt + CNT_W'(1);
    assign w_pairs2 = w_n * (w_n - CNT_W'(1));
    assign w_bad    = (w_n < CNT_W'(2)) || (w_rank == '0) ||
                      (TW'({w_rank, 1'b0}) > TW'(w_pairs2));

    assign w_top     = w_ent[0];
    assign w_advance = ({1'b0, w_top.j} > ({1'b0, w_top.i} + (IDX_W+1)'(1)));

    // A result enters the output register on an error request or when the
    // last removal is done.
    assign w_out_load = ((r_state == S_LOAD) && w_in_acc && i_s_axis_tlast && w_bad) ||
                        ((r_state == S_PSEL) && (r_pops == '0) && w_out_free);

    always_comb begin
        w_op      = OP_HOLD;
        w_x       = '0;
        w_rd_addr = r_i;
        case (r_state)
            S_LOAD: begin
                if (w_in_acc && i_s_axis_tlast && !w_bad) begin
                    w_op = OP_CLEAR;
                end
            end
            S_QRD: w_rd_addr = r_nm1;
            S_QCAP: w_rd_addr = r_i;
            S_SRD: w_rd_addr = r_i;
            S_SINS: begin
                w_op = OP_INSERT;
                w_x  = '{valid: 1'b1, i: r_i, j: r_nm1, vi: r_rd, vj: r_vq};
            end
            S_PSEL: begin
                w_rd_addr = w_top.j - IDX_W'(1);
                if ((r_pops != '0) && !w_advance) begin
                    w_op = OP_POP;
                end
            end
            S_PREP: begin
                w_op = OP_REPL;
                w_x  = '{valid: 1'b1, i: w_top.i, j: w_top.j - IDX_W'(1),
                         vi: w_top.vi, vj: r_rd};
            end
            default: w_op = OP_HOLD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && !w_full) begin
            r_mem[r_cnt[IDX_W-1:0]] <= w_value;
        end
        r_rd <= r_mem[w_rd_addr];
    end

    assign w_ent[NCELL] = '0;
    assign w_b[NCELL]   = 1'b0;

    for (genvar c = 0; c < NCELL; c++) begin : g_cell
        kfh_cell #(
            .IDX_W (IDX_W),
            .VB    (VB),
            .ENT_W (ENT_W)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_op        (w_op),
            .i_first     (c == 0),
            .i_x         (w_x),
            .i_left_ent  ((c == 0) ? w_ent[NCELL] : w_ent[(c == 0) ? 0 : c - 1]),
            .i_left_b    ((c == 0) ? 1'b1 : w_b[(c == 0) ? 0 : c - 1]),
            .i_right_ent (w_ent[c+1]),
            .i_right_b   (w_b[c+1]),
            .o_ent       (w_ent[c]),
            .o_b         (w_b[c])
        );
        assign w_valid[c] = w_ent[c][ENT_W-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_cnt       <= '0;
            r_pops      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_LOAD: begin
                    if (w_in_acc) begin
                        if (i_s_axis_tlast) begin
                            r_cnt <= '0;
                            if (w_bad) begin
                                r_num <= '0;
                                r_den <= '0;
                                r_err <= 1'b1;
                            end else begin
                                r_nm1   <= IDX_W'(w_n - CNT_W'(1));
                                r_pops  <= w_rank - RANK_W'(1);
                                r_i     <= '0;
                                r_state <= S_QRD;
                            end
                        end else if (!w_full) begin
                            r_cnt <= r_cnt + CNT_W'(1);
                        end
                    end
                end
                S_QRD: r_state <= S_QCAP;
                S_QCAP: begin
                    r_vq    <= r_rd;
                    r_state <= S_SINS;
                end
                S_SRD: r_state <= S_SINS;
                S_SINS: begin
                    if (r_i == r_nm1 - IDX_W'(1)) begin
                        r_state <= S_PSEL;
                    end else begin
                        r_i     <= r_i + IDX_W'(1);
                        r_state <= S_SRD;
                    end
                end
                S_PSEL: begin
                    if (r_pops == '0) begin
                        if (w_out_free) begin
                            r_num   <= w_top.vi;
                            r_den   <= w_top.vj;
                            r_err   <= 1'b0;
                            r_state <= S_LOAD;
                        end
                    end else if (w_advance) begin
                        r_state <= S_PREP;
                    end else begin
                        r_pops <= r_pops - RANK_W'(1);
                    end
                end
                S_PREP: begin
                    r_pops  <= r_pops - RANK_W'(1);
                    r_state <= S_PSEL;
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_W'({r_den, r_num});
    assign o_m_axis_tuser  = r_err;

    // Occupied cells always form an unbroken run from the head.
    `ASSERT_ALWAYS(a_chain_packed, i_clk, i_rst_n, ((w_valid + NCELL'(1)) & w_valid) == '0)
    // A valid request never runs the chain dry before the answer.
    `ASSERT_IMPLIES(a_head_valid, i_clk, i_rst_n, r_state == S_PSEL, w_top.valid)
    // A replacement step only happens with removals still owed.
    `ASSERT_IMPLIES(a_repl_owed, i_clk, i_rst_n, r_state == S_PREP, r_pops != '0)
endmodule
`default_nettype wire

/* rtl/kfh_cell.sv */
// ----------------------------------------------------------------------------
// kfh_cell
// One slot of the sorted entry chain: holds an index pair with its cached
// values and moves entries to or from its neighbors.
// ----------------------------------------------------------------------------
`default_nettype none
module kfh_cell
    import kfh_pkg::*;
#(
    parameter int IDX_W = 11,
    parameter int VB    = 15,
    parameter int ENT_W = 1 + 2 * IDX_W + 2 * VB
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_op              i_op,
    input  wire logic             i_first,
    input  wire logic [ENT_W-1:0] i_x,
    input  wire logic [ENT_W-1:0] i_left_ent,
    input  wire logic             i_left_b,
    input  wire logic [ENT_W-1:0] i_right_ent,
    input  wire logic             i_right_b,
    output logic      [ENT_W-1:0] o_ent,
    output logic                  o_b
);
    typedef struct packed {
        logic            valid;
        logic [IDX_W-1:0] i;
        logic [IDX_W-1:0] j;
        logic [VB-1:0]    vi;
        logic [VB-1:0]    vj;
    } t_ent;

    t_ent r_ent, n_ent, w_x, w_left, w_right;
    logic [2*VB-1:0] w_lhs, w_rhs;

    assign w_x     = i_x;
    assign w_left  = i_left_ent;
    assign w_right = i_right_ent;

    // This entry comes before the broadcast one: smaller ratio, or an equal
    // ratio with the larger numerator index.
    assign w_lhs = r_ent.vi * w_x.vj;
    assign w_rhs = w_x.vi * r_ent.vj;
    assign o_b   = r_ent.valid && ((w_lhs < w_rhs) || ((w_lhs == w_rhs) && (r_ent.i > w_x.i)));
    assign o_ent = r_ent;

    always_comb begin
        n_ent = r_ent;
        case (i_op)
            OP_HOLD:   n_ent = r_ent;
            OP_CLEAR:  n_ent.valid = 1'b0;
            OP_INSERT: n_ent = o_b ? r_ent : (i_left_b ? w_x : w_left);
            OP_POP:    n_ent = w_right;
            OP_REPL:   n_ent = i_right_b ? w_right : ((i_first || o_b) ? w_x : r_ent);
            default:   n_ent = r_ent;
        endcase
    end

    // Only the valid bit is reset; the payload follows it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent.valid <= 1'b0;
        end else begin
            r_ent.valid <= n_ent.valid;
        end
        r_ent.i  <= n_ent.i;
        r_ent.j  <= n_ent.j;
        r_ent.vi <= n_ent.vi;
        r_ent.vj <= n_ent.vj;
    end
endmodule
`default_nettype wire

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the k-th smallest pair fraction selector.
// ----------------------------------------------------------------------------
// Lists are queued as stream transfers by an initial block. A clocked driver
// presents them on the slave stream, and a clocked monitor checks every
// master-stream transfer against a scoreboard. The scoreboard is filled by a
// behavioral selector that repeats the row-merge procedure with exact cross
// products, where ties go to the larger numerator index.
// ----------------------------------------------------------------------------
module tb_top;
    import kfh_pkg::*;

    localparam int LIST_MAX  = 2048;
    localparam int VAL_MAX   = 32767;
    localparam int RANK_MAX  = 4194303;
    localparam int IN_BITS   = 40;
    localparam int OUT_BITS  = 32;

    typedef struct {
        logic [14:0] value;
        logic [21:0] rank;
        logic        last;
    } list_item_t;

    typedef struct {
        logic [14:0] numerator;
        logic [14:0] denominator;
        logic        error;
    } fraction_t;

    logic                i_clk;
    logic                i_rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [IN_BITS-1:0]  s_tdata;
    logic                s_tlast;
    logic                m_tvalid;
    logic                m_tready;
    logic [OUT_BITS-1:0] m_tdata;
    logic                m_tuser;

    kth_smallest_fraction_heap dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    list_item_t  pending_items[$];
    fraction_t   expected_fractions[$];
    logic [14:0] list_values[LIST_MAX];
    int          list_len;
    int          row_denom[LIST_MAX];
    bit          row_live[LIST_MAX];
    int          items_accepted;
    int          fail_count;
    bit          stimulus_ready;
    bit          in_fire;
    int          holdoff_left;
    bit          holdoff_done;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Ordering of two rows by their current fractions, exact through cross
    // products; equal fractions favor the larger numerator index.
    function automatic bit row_precedes(int a, int b);
        longint unsigned lhs;
        longint unsigned rhs;
        lhs = longint'(list_values[a]) * longint'(list_values[row_denom[b]]);
        rhs = longint'(list_values[b]) * longint'(list_values[row_denom[a]]);
        if (lhs != rhs) begin
            return lhs < rhs;
        end
        return a > b;
    endfunction

    function automatic int smallest_row(int n);
        int best;
        best = -1;
        for (int r = 0; r < n - 1; r++) begin
            if (row_live[r] && (best < 0 || row_precedes(r, best))) begin
                best = r;
            end
        end
        return best;
    endfunction

    // Works out the selected fraction for the list held in list_values.
    function automatic fraction_t select_fraction(int n, int unsigned k);
        fraction_t res;
        longint    total;
        int        best;
        total = (longint'(n) * longint'(n > 0 ? n - 1 : 0)) / 2;
        res = '{numerator: '0, denominator: '0, error: 1'b1};
        if (n < 2 || k == 0 || longint'(k) > total) begin
            return res;
        end
        for (int r = 0; r < n - 1; r++) begin
            row_denom[r] = n - 1;
            row_live[r]  = 1'b1;
        end
        for (int unsigned p = 1; p < k; p++) begin
            best = smallest_row(n);
            row_denom[best]--;
            if (row_denom[best] <= best) begin
                row_live[best] = 1'b0;
            end
        end
        best = smallest_row(n);
        res.numerator   = list_values[best];
        res.denominator = list_values[row_denom[best]];
        res.error       = 1'b0;
        return res;
    endfunction

    // Queues one list; mode picks the value pattern, rank goes on the last item.
    task automatic queue_list(input int n, input int unsigned rank, input int mode);
        list_item_t it;
        int         v;
        v = (mode == 3) ? VAL_MAX - $urandom_range(4 * n + 8, 0) : $urandom_range(1, 3);
        if (v < 1) begin
            v = 1;
        end
        for (int e = 0; e < n; e++) begin
            case (mode)
                1: v = $urandom_range(VAL_MAX, 1);
                2: v = $urandom_range(4, 1);
                default: begin
                    if (e > 0) begin
                        v = v + $urandom_range(mode == 3 ? 3 : 40, 0);
                    end
                    if (v > VAL_MAX) begin
                        v = VAL_MAX;
                    end
                end
            endcase
            it.value = v[14:0];
            it.last  = (e == n - 1);
            it.rank  = it.last ? rank[21:0] : 22'($urandom_range(RANK_MAX, 0));
            pending_items.push_back(it);
        end
    endtask

    function automatic int unsigned pair_total(int n);
        return n * (n - 1) / 2;
    endfunction

    initial begin
        int n;
        int unsigned k;
        int          queued;
        list_item_t  it;
        // Directed part: short lists, rank limits, top values, odd orderings.
        queue_list(1, 1, 0);
        queue_list(2, 1, 0);
        queue_list(2, 0, 0);
        queue_list(2, 2, 0);
        queue_list(2, RANK_MAX, 0);
        queue_list(3, 3, 3);
        queue_list(4, 6, 1);
        queue_list(4, 2, 2);
        it = '{value: 15'd1, rank: 22'd0, last: 1'b0};
        pending_items.push_back(it);
        it = '{value: 15'd32767, rank: 22'd1, last: 1'b1};
        pending_items.push_back(it);
        // Random part: mostly valid ranks on small lists.
        queued = pending_items.size();
        while (queued < 1550) begin
            case ($urandom_range(19, 0))
                0:       n = 1;
                1:       n = $urandom_range(64, 13);
                default: n = $urandom_range(12, 2);
            endcase
            case ($urandom_range(9, 0))
                0: k = 0;
                1: k = pair_total(n);
                2: k = pair_total(n) + 1;
                3: k = $urandom_range(RANK_MAX, 0);
                default: k = $urandom_range(pair_total(n) > 0 ? pair_total(n) : 1, 1);
            endcase
            queue_list(n, k, $urandom_range(3, 0));
            queued += n;
        end
        stimulus_ready = 1'b1;
    end

    // Idle mix rotates every 400 accepted items: none, sender, receiver, both.
    function automatic bit roll_idle(bit sender_side);
        int phase;
        phase = (items_accepted / 400) % 4;
        if (phase == 3) begin
            return $urandom_range(99, 0) < 35;
        end
        if ((phase == 1 && sender_side) || (phase == 2 && !sender_side)) begin
            return $urandom_range(99, 0) < 59;
        end
        return 1'b0;
    endfunction

    // Sampling side: input transfers feed the predictor, output transfers are
    // checked against the oldest expectation.
    always @(posedge i_clk) begin
        fraction_t got;
        fraction_t want;
        in_fire <= s_tvalid && s_tready;
        if (i_rst_n && s_tvalid && s_tready) begin
            items_accepted++;
            if (list_len < LIST_MAX) begin
                list_values[list_len] = s_tdata[14:0];
                list_len++;
            end
            if (s_tlast) begin
                expected_fractions.push_back(select_fraction(list_len, s_tdata[36:15]));
                list_len = 0;
            end
        end
        if (i_rst_n && m_tvalid && m_tready) begin
            got.numerator   = m_tdata[14:0];
            got.denominator = m_tdata[29:15];
            got.error       = m_tuser;
            if (expected_fractions.size() == 0) begin
                $display("%0t: unexpected result num=%0d den=%0d err=%0b", $time,
                         got.numerator, got.denominator, got.error);
                fail_count++;
            end else begin
                want = expected_fractions.pop_front();
                if (got.numerator !== want.numerator) begin
                    $display("%0t: numerator expected %0d actual %0d", $time,
                             want.numerator, got.numerator);
                    fail_count++;
                end
                if (got.denominator !== want.denominator) begin
                    $display("%0t: denominator expected %0d actual %0d", $time,
                             want.denominator, got.denominator);
                    fail_count++;
                end
                if (got.error !== want.error) begin
                    $display("%0t: error flag expected %0b actual %0b", $time,
                             want.error, got.error);
                    fail_count++;
                end
            end
        end
    end

    // Slave-stream driver: a new item goes out once the previous transfer
    // has completed, unless the sender decides to idle this cycle.
    always @(negedge i_clk) begin
        list_item_t it;
        if (i_rst_n && stimulus_ready && (!s_tvalid || in_fire)) begin
            if (pending_items.size() > 0 && !roll_idle(1'b1)) begin
                it = pending_items.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {3'b000, it.rank, it.value};
                s_tlast  <= it.last;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off while the sender keeps
    // offering, so that the output register fills and the input backs up.
    always @(negedge i_clk) begin
        if (!holdoff_done && items_accepted >= 200) begin
            holdoff_done <= 1'b1;
            holdoff_left <= 600;
            m_tready     <= 1'b0;
        end else if (holdoff_left > 0) begin
            holdoff_left <= holdoff_left - 1;
            m_tready     <= 1'b0;
        end else begin
            m_tready <= !roll_idle(1'b0);
        end
    end

    initial begin
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tlast        = 1'b0;
        m_tready       = 1'b0;
        i_rst_n        = 1'b0;
        list_len       = 0;
        items_accepted = 0;
        fail_count     = 0;
        holdoff_left   = 0;
        holdoff_done   = 1'b0;
        in_fire        = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        wait (stimulus_ready);
        do begin
            @(posedge i_clk);
        end while (pending_items.size() > 0 || s_tvalid || expected_fractions.size() > 0);
        repeat (40) @(posedge i_clk);
        if (fail_count == 0 && expected_fractions.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Watchdog well beyond the slowest legal run.
    initial begin
        #16000000;
        $display("Regression FAIL");
        $finish;
    end
endmodule
